// ----- rtl/etd_pkg.sv -----
// Shared types, codes and helper functions of the escaped timestamp decoder.
// Used by every module and interface of the block; depends on nothing.
package etd_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned CH_W   = 8;
  localparam int unsigned TS_W   = 33;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned HEX_W  = 5;
  localparam int unsigned EXT_W  = 64;

  // Characters of an escape sequence.
  localparam logic [CH_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CH_X         = 8'h78;
  localparam logic [CH_W-1:0] CH_0         = 8'h30;
  localparam logic [CH_W-1:0] CH_9         = 8'h39;
  localparam logic [CH_W-1:0] CH_LA        = 8'h61;
  localparam logic [CH_W-1:0] CH_LF        = 8'h66;
  localparam logic [CH_W-1:0] CH_UA        = 8'h41;
  localparam logic [CH_W-1:0] CH_UF        = 8'h46;

  // Marks a character that is not a hex digit.
  localparam logic [HEX_W-1:0] HEX_NONE = 5'd16;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_ESCAPE = 3'd1,
    ST_SHORT      = 3'd2,
    ST_TRAILING   = 3'd3,
    ST_RANGE      = 3'd4
  } status_e;

  // Parser phase within the escaped string.
  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_X     = 2'd1,
    PH_HI    = 2'd2,
    PH_LO    = 2'd3
  } phase_e;

  // One input word as held in the input register.
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            has_char;
    logic            is_end;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [TS_W-1:0] timestamp;
    status_e         status;
  } res_word_t;

  // Value of a hex digit, upper or lower case, or HEX_NONE.
  function automatic logic [HEX_W-1:0] hex_value(input logic [CH_W-1:0] c);
    logic [HEX_W-1:0] v;
    v = HEX_NONE;
    if (c >= CH_0 && c <= CH_9) begin
      v = HEX_W'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = HEX_W'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = HEX_W'(c - CH_UA + 8'd10);
    end
    return v;
  endfunction

endpackage

// ----- rtl/etd_stream_if.sv -----
// Valid/ready stream interfaces for the input characters and the results.
// Depends on etd_pkg for the field widths.
interface etd_in_if;
  logic                       valid;
  logic                       ready;
  logic [etd_pkg::CH_W-1:0]   ch;
  logic                       has_char;
  logic                       is_end;

  modport source (output valid, ch, has_char, is_end, input ready);
  modport sink   (input valid, ch, has_char, is_end, output ready);
endinterface

interface etd_out_if;
  logic                       valid;
  logic                       ready;
  logic [etd_pkg::TS_W-1:0]   timestamp;
  logic [etd_pkg::ST_W-1:0]   status;

  modport source (output valid, timestamp, status, input ready);
  modport sink   (input valid, timestamp, status, output ready);
endinterface

// ----- rtl/escaped_timestamp_decoder.sv -----
// Escaped timestamp decoder: input register, parser step, result register.
// An accepted end word is held in the input register, and its result then in the result register.
// Throughput: one character word per cycle; the held word advances unless
// it is an end word while a result waits in the output register and the sink stalls.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to the start of a string.
module escaped_timestamp_decoder #(
  parameter int unsigned NUM_BYTES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  etd_in_if.sink    in_i,
  etd_out_if.source out_o
);

  logic               in_valid_q;
  etd_pkg::in_word_t  in_q;
  logic               out_valid_q;
  etd_pkg::res_word_t out_q;

  logic               out_free;
  logic               advance;
  logic               emit;
  etd_pkg::res_word_t res;

  // The held word moves on unless it carries a result with nowhere to go.
  assign out_free  = !out_valid_q || out_o.ready;
  assign advance   = in_valid_q && (!in_q.is_end || out_free);
  assign in_i.ready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.ch       <= in_i.ch;
      in_q.has_char <= in_i.has_char;
      in_q.is_end   <= in_i.is_end;
    end
  end

  etd_step #(
    .NUM_BYTES(NUM_BYTES)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .word_i (in_q),
    .emit_o (emit),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.timestamp = out_q.timestamp;
  assign out_o.status    = out_q.status;

endmodule

// ----- rtl/etd_step.sv -----
// Parser state and its update for one registered input word.
// Depends on etd_pkg for types, codes and the hex digit decode.
module etd_step #(
  parameter int unsigned NUM_BYTES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  etd_pkg::in_word_t  word_i,
  output logic               emit_o,
  output etd_pkg::res_word_t res_o
);

  localparam int unsigned VW = NUM_BYTES * 8;

  etd_pkg::phase_e                 ph_q, ph_d;
  logic [etd_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [VW-1:0]                   val_q, val_d;
  logic [etd_pkg::NIB_W-1:0]       hi_q, hi_d;
  etd_pkg::status_e                err_q, err_d;

  logic [etd_pkg::HEX_W-1:0]       dig;
  logic                            push;
  logic [7:0]                      push_byte;
  logic [etd_pkg::EXT_W-1:0]       val_ext;
  etd_pkg::status_e                st;

  assign dig = etd_pkg::hex_value(word_i.ch);

  // Character step, then the end-of-string check on the updated state.
  always_comb begin
    ph_d      = ph_q;
    cnt_d     = cnt_q;
    val_d     = val_q;
    hi_d      = hi_q;
    err_d     = err_q;
    push      = 1'b0;
    push_byte = word_i.ch;

    if (fire_i && word_i.has_char && err_q == etd_pkg::ST_OK) begin
      unique case (ph_q)
        etd_pkg::PH_PLAIN: begin
          if (cnt_q >= etd_pkg::CNT_W'(NUM_BYTES)) begin
            err_d = etd_pkg::ST_TRAILING;
          end else if (word_i.ch == etd_pkg::CH_BACKSLASH) begin
            ph_d = etd_pkg::PH_X;
          end else begin
            push = 1'b1;
          end
        end
        etd_pkg::PH_X: begin
          if (word_i.ch == etd_pkg::CH_X) begin
            ph_d = etd_pkg::PH_HI;
          end else begin
            err_d = etd_pkg::ST_BAD_ESCAPE;
          end
        end
        etd_pkg::PH_HI: begin
          if (dig == etd_pkg::HEX_NONE) begin
            err_d = etd_pkg::ST_BAD_ESCAPE;
          end else begin
            hi_d = dig[etd_pkg::NIB_W-1:0];
            ph_d = etd_pkg::PH_LO;
          end
        end
        etd_pkg::PH_LO: begin
          if (dig == etd_pkg::HEX_NONE) begin
            err_d = etd_pkg::ST_BAD_ESCAPE;
          end else begin
            push      = 1'b1;
            push_byte = {hi_q, dig[etd_pkg::NIB_W-1:0]};
            ph_d      = etd_pkg::PH_PLAIN;
          end
        end
        default: ;
      endcase
    end

    // Shift the new byte in at the low end; older bytes move up.
    if (push) begin
      val_d = VW'({val_q, push_byte});
      cnt_d = cnt_q + 1'b1;
    end

    val_ext = etd_pkg::EXT_W'(val_d);

    // Status at the end of the string; the first error wins.
    priority if (err_d != etd_pkg::ST_OK) begin
      st = err_d;
    end else if (ph_d != etd_pkg::PH_PLAIN) begin
      st = etd_pkg::ST_BAD_ESCAPE;
    end else if (cnt_d < etd_pkg::CNT_W'(NUM_BYTES)) begin
      st = etd_pkg::ST_SHORT;
    end else if (|val_ext[etd_pkg::EXT_W-1:etd_pkg::TS_W]) begin
      st = etd_pkg::ST_RANGE;
    end else begin
      st = etd_pkg::ST_OK;
    end

    emit_o          = fire_i && word_i.is_end;
    res_o.status    = st;
    res_o.timestamp = (st == etd_pkg::ST_OK) ? val_ext[etd_pkg::TS_W-1:0] : '0;

    // The end of a string returns the parser to its initial state.
    if (emit_o) begin
      ph_d  = etd_pkg::PH_PLAIN;
      cnt_d = '0;
      val_d = '0;
      hi_d  = '0;
      err_d = etd_pkg::ST_OK;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= etd_pkg::PH_PLAIN;
      cnt_q <= '0;
      val_q <= '0;
      hi_q  <= '0;
      err_q <= etd_pkg::ST_OK;
    end else begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      val_q <= val_d;
      hi_q  <= hi_d;
      err_q <= err_d;
    end
  end

endmodule

// ----- rtl/etd_checker.sv -----
// Port-level checks of the escaped timestamp decoder, bound to the top level.
// Depends on etd_pkg for the status codes.
module etd_port_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [etd_pkg::TS_W-1:0] out_timestamp_i,
  input logic [etd_pkg::ST_W-1:0] out_status_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_timestamp_i) && $stable(out_status_i))
    else $error("result word changed while stalled");

  // Every failed decode reports a zero timestamp.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != etd_pkg::ST_OK |-> out_timestamp_i == '0)
    else $error("nonzero timestamp with an error status");

  // Only the defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i == etd_pkg::ST_OK ||
                     out_status_i == etd_pkg::ST_BAD_ESCAPE ||
                     out_status_i == etd_pkg::ST_SHORT ||
                     out_status_i == etd_pkg::ST_TRAILING ||
                     out_status_i == etd_pkg::ST_RANGE))
    else $error("undefined status code");

endmodule

bind escaped_timestamp_decoder etd_port_checker u_etd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_timestamp_i (out_o.timestamp),
  .out_status_i    (out_o.status)
);
